/* hw/rtl/srt_pkg.sv */
// Package: shared constants, status codes and control structs for the slice tracker.
package srt_pkg;
    localparam int ENTRIES         = 8;
    localparam int MAX_SLICES      = 64;
    localparam int MAX_SLICE_BYTES = 1024;
    localparam int IDX_W           = $clog2(ENTRIES);
    localparam logic [31:0] DEFAULT_TIMEOUT_MS = 32'd10000;

    localparam logic [2:0] ST_NEW  = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_DONE = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_BAD  = 3'd4;
    localparam logic [2:0] ST_TICK = 3'd5;

    typedef struct packed {
        logic       load;    // capture input word
        logic       exec;    // perform lookup result / table update
    } t_cmd;

    typedef struct packed {
        logic       busy;
    } t_stat;
endpackage

/* hw/rtl/srt_if.sv */
// Interfaces: valid/ready channels for slice requests, results and configuration.
interface srt_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] chunk_id;
    logic [47:0] sender_addr;
    logic [6:0]  slice_total;
    logic [5:0]  slice_index;
    logic [10:0] slice_bytes;
    logic [31:0] now_ms;
    modport source (output valid, req_type, chunk_id, sender_addr, slice_total,
                    slice_index, slice_bytes, now_ms, input ready);
    modport sink   (input valid, req_type, chunk_id, sender_addr, slice_total,
                    slice_index, slice_bytes, now_ms, output ready);
endinterface

interface srt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  entry_index;
    logic [63:0] ack_bitmap;
    logic [15:0] write_offset;
    logic [16:0] chunk_bytes;
    logic [7:0]  dropped_mask;
    modport source (output valid, status, entry_index, ack_bitmap, write_offset,
                    chunk_bytes, dropped_mask, input ready);
    modport sink   (input valid, status, entry_index, ack_bitmap, write_offset,
                    chunk_bytes, dropped_mask, output ready);
endinterface

interface srt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/srt_ctrl.sv */
// Controller: sequences load and execute of one word, holds result valid.
module srt_ctrl
    import srt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // a loaded word is executed when the result slot is empty or drains now
    wire w_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || i_out_ready)) else $error("exec over result");
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC) else $error("load not followed by exec");
    a_valid_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_cmd.exec) |-> r_out_valid) else $error("result lost");
endmodule

/* hw/rtl/srt_dp.sv */
// Datapath: entry table, key match, slot update, timeout sweep, result register.
module srt_dp
    import srt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_req_type,
    input  logic [31:0] i_chunk_id,
    input  logic [47:0] i_sender_addr,
    input  logic [6:0]  i_slice_total,
    input  logic [5:0]  i_slice_index,
    input  logic [10:0] i_slice_bytes,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output logic [2:0]  o_status,
    output logic [2:0]  o_entry_index,
    output logic [63:0] o_ack_bitmap,
    output logic [15:0] o_write_offset,
    output logic [16:0] o_chunk_bytes,
    output logic [7:0]  o_dropped_mask
);
    // captured word
    logic        r_type;
    logic [31:0] r_id;
    logic [47:0] r_snd;
    logic [6:0]  r_tot;
    logic [5:0]  r_sidx;
    logic [10:0] r_bytes;
    logic [31:0] r_now;
    logic [31:0] r_timeout;

    // table
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [31:0] r_e_id   [ENTRIES];
    logic [47:0] r_e_snd  [ENTRIES];
    logic [6:0]  r_e_tot  [ENTRIES];
    logic [63:0] r_e_mask [ENTRIES];
    logic [6:0]  r_e_cnt  [ENTRIES];
    logic [31:0] r_e_time [ENTRIES];
    logic [16:0] r_e_len  [ENTRIES];

    logic [ENTRIES-1:0] w_hit, w_old;
    logic [IDX_W-1:0]   w_slot;
    logic               w_any_hit, w_any_free, w_bad, w_dup, w_last, w_done;
    logic               w_open, w_upd;
    logic [63:0]        w_cur_mask, w_bit, w_new_mask;
    logic [6:0]         w_cur_cnt, w_new_cnt;
    logic [16:0]        w_cur_len, w_new_len;
    logic [7:0]         w_drop8;

    // next result word
    logic [2:0]         n_status, n_index;
    logic [63:0]        n_ack;
    logic [15:0]        n_off;
    logic [16:0]        n_len;
    logic [7:0]         n_drop;

    always_comb begin
        w_bad = (r_tot == 7'd0) || (r_tot > 7'(MAX_SLICES)) || ({1'b0, r_sidx} >= r_tot)
             || (r_bytes == 11'd0) || (r_bytes > 11'(MAX_SLICE_BYTES));
        for (int i = 0; i < ENTRIES; i++) begin
            w_hit[i] = r_valid[i] && r_e_id[i] == r_id && r_e_snd[i] == r_snd
                    && r_e_tot[i] == r_tot;
            w_old[i] = r_valid[i] && ({1'b0, r_e_time[i]} + {1'b0, r_timeout}
                    < {1'b0, r_now});
        end
        w_any_hit  = |w_hit;
        w_any_free = ~&r_valid;
        w_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_any_hit ? w_hit[i] : !r_valid[i]) w_slot = IDX_W'(i);
        end
        // a freshly opened slot starts empty
        w_cur_mask = w_any_hit ? r_e_mask[w_slot] : 64'd0;
        w_cur_cnt  = w_any_hit ? r_e_cnt[w_slot]  : 7'd0;
        w_cur_len  = w_any_hit ? r_e_len[w_slot]  : 17'd0;
        w_bit      = 64'd1 << r_sidx;
        w_dup      = |(w_cur_mask & w_bit);
        w_new_mask = w_cur_mask | w_bit;
        w_new_cnt  = w_cur_cnt + 7'd1;
        w_last     = ({1'b0, r_sidx} == r_tot - 7'd1);
        w_new_len  = w_last ? 17'((r_tot - 7'd1) * 17'(MAX_SLICE_BYTES) + 17'(r_bytes))
                            : w_cur_len;
        w_done     = (w_new_cnt == r_tot);
        w_drop8    = '0;
        for (int i = 0; i < ENTRIES && i < 8; i++) w_drop8[i] = w_old[i];
        // key fields on open; a fresh slot never holds a duplicate
        w_open = !r_type && !w_bad && !w_any_hit && w_any_free;
        w_upd  = !r_type && !w_bad && (w_any_hit || w_any_free) && !w_dup;
        n_valid = r_valid;
        if (i_cmd.exec) begin
            if (r_type) n_valid = r_valid & ~w_old;
            else if (!w_bad && (w_any_hit || w_any_free) && !w_dup)
                n_valid[w_slot] = !w_done;
            else if (!w_bad && !w_any_hit && w_any_free)
                n_valid[w_slot] = 1'b1;
        end

        n_status = ST_TICK;
        n_index  = '0;
        n_ack    = '0;
        n_off    = '0;
        n_len    = '0;
        n_drop   = '0;
        if (r_type) begin
            n_drop = w_drop8;
        end else if (w_bad) begin
            n_status = ST_BAD;
        end else if (!w_any_hit && !w_any_free) begin
            n_status = ST_FULL;
        end else begin
            n_index = 3'(w_slot);
            if (w_dup) begin
                n_status = ST_DUP;
            end else begin
                n_status = w_done ? ST_DONE : ST_NEW;
                n_ack    = w_new_mask;
                n_off    = 16'({10'd0, r_sidx} * 16'(MAX_SLICE_BYTES));
                n_len    = w_done ? w_new_len : 17'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_timeout <= DEFAULT_TIMEOUT_MS;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type  <= i_req_type;
            r_id    <= i_chunk_id;
            r_snd   <= i_sender_addr;
            r_tot   <= i_slice_total;
            r_sidx  <= i_slice_index;
            r_bytes <= i_slice_bytes;
            r_now   <= i_now_ms;
        end
        if (i_cmd.exec) begin
            o_status       <= n_status;
            o_entry_index  <= n_index;
            o_ack_bitmap   <= n_ack;
            o_write_offset <= n_off;
            o_chunk_bytes  <= n_len;
            o_dropped_mask <= n_drop;
            if (w_open) begin
                r_e_id[w_slot]  <= r_id;
                r_e_snd[w_slot] <= r_snd;
                r_e_tot[w_slot] <= r_tot;
            end
            if (w_upd) begin
                r_e_mask[w_slot] <= w_new_mask;
                r_e_cnt[w_slot]  <= w_new_cnt;
                r_e_time[w_slot] <= r_now;
                r_e_len[w_slot]  <= w_new_len;
            end
        end
    end

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $onehot0(w_hit)) else $error("duplicate key in table");
    a_tick_only_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_type) |=> (r_valid & ~$past(r_valid)) == '0)
        else $error("tick opened an entry");
    a_bad_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !r_type && w_bad) |=> $stable(r_valid))
        else $error("invalid slice changed table");
endmodule

/* hw/rtl/slice_reassembly_tracker_unit.sv */
// Top level: slice reassembly tracker, controller plus table datapath.
// Each word is captured into the input registers, then one table read-modify-write
// writes the result register; that step waits while the held result is still untaken.
// The result register frees as it is taken, so a new word is taken while a result waits.
// Reset (i_rst_n low, synchronous): all entries invalid, timeout 10000 ms, no result.
// Entry fields other than the valid bits are not reset; they are written on open.
module slice_reassembly_tracker_unit
    import srt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    srt_req_if.sink   req,
    srt_rsp_if.source rsp,
    srt_cfg_if.sink   cfg
);
    t_cmd w_cmd;

    // configuration is always accepted; the user must write it only while idle (not enforced)
    assign cfg.ready = 1'b1;

    srt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req.valid),
        .o_in_ready  (req.ready),
        .o_out_valid (rsp.valid),
        .i_out_ready (rsp.ready),
        .o_cmd       (w_cmd)
    );

    srt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req_type     (req.req_type),
        .i_chunk_id     (req.chunk_id),
        .i_sender_addr  (req.sender_addr),
        .i_slice_total  (req.slice_total),
        .i_slice_index  (req.slice_index),
        .i_slice_bytes  (req.slice_bytes),
        .i_now_ms       (req.now_ms),
        .i_cfg_we       (cfg.valid),
        .i_cfg_data     (cfg.data),
        .o_status       (rsp.status),
        .o_entry_index  (rsp.entry_index),
        .o_ack_bitmap   (rsp.ack_bitmap),
        .o_write_offset (rsp.write_offset),
        .o_chunk_bytes  (rsp.chunk_bytes),
        .o_dropped_mask (rsp.dropped_mask)
    );
endmodule
